// ----- rtl/cccl_pkg.sv -----
// Package for the cell chunk LRU cache: sizes, slot entry layout and status codes.
// Depends on nothing; used by the top level.
`default_nettype none
package cccl_pkg;

  localparam int SLOTS   = 64;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int CFG_W   = 7;
  localparam int BUD_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int COORD_W = 16;
  localparam int STAMP_W = 32;
  localparam int ENTRY_W = 2 * COORD_W + STAMP_W;

  localparam logic [2:0] ST_HIT   = 3'd0;
  localparam logic [2:0] ST_BUILT = 3'd1;
  localparam logic [2:0] ST_EVICT = 3'd2;
  localparam logic [2:0] ST_SKIP  = 3'd3;
  localparam logic [2:0] ST_FRAME = 3'd4;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

endpackage
`default_nettype wire

// ----- rtl/cccl_ram.sv -----
// Generic simple dual-port RAM, one write port and one registered read port.
// Depends on nothing.
`default_nettype none
module cccl_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/cell_chunk_cache_lru.sv -----
// Top level of the cell chunk LRU cache: control sequencer, scan and result register.
// Depends on cccl_pkg and cccl_ram.
//
//  channel | ports                                    | direction
//  in      | in_valid in_stall in_kind in_cell_x/z    | request in
//  out     | out_valid out_stall out_slot out_status  | result out
//          | out_evicted_x out_evicted_z              |
//  cfg     | cfg_wr_en cfg_wr_data (build budget)     | register write
//
// Frame start: the request goes from S_IDLE straight to S_FIN, then to the result register.
// Cell request: S_SCAN reads the occupied slots one at a time from the tag/stamp RAM port
// (stops at a hit); a miss goes through S_MISS, then S_FIN and the result register.
// Reset initialises only the control registers; RAM entries are read only once written.
// A waiting result does not block the next request; a finished one waits for out_stall low.
`default_nettype none
module cell_chunk_cache_lru (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_kind,
  input  wire logic signed [cccl_pkg::COORD_W-1:0] in_cell_x,
  input  wire logic signed [cccl_pkg::COORD_W-1:0] in_cell_z,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [5:0]                            out_slot,
  output logic [2:0]                            out_status,
  output logic signed [cccl_pkg::COORD_W-1:0]   out_evicted_x,
  output logic signed [cccl_pkg::COORD_W-1:0]   out_evicted_z,
  input  wire logic                             cfg_wr_en,
  input  wire logic [cccl_pkg::CFG_W-1:0]       cfg_wr_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_MISS = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]                     state_r, state_nxt;
  logic [cccl_pkg::SLOT_W-1:0]    idx_r, idx_nxt;
  logic [cccl_pkg::CNT_W-1:0]     used_r, used_nxt;
  logic [cccl_pkg::STAMP_W-1:0]   frame_r, frame_nxt;
  logic [cccl_pkg::BUD_W-1:0]     built_r, built_nxt;
  logic [cccl_pkg::BUD_W-1:0]     fbud_r, fbud_nxt;
  logic [cccl_pkg::CFG_W-1:0]     budget_r;
  logic                           out_valid_r, out_valid_nxt;

  logic [cccl_pkg::COORD_W-1:0]   cx_r, cx_nxt, cz_r, cz_nxt;
  logic [cccl_pkg::SLOT_W-1:0]    min_slot_r, min_slot_nxt;
  logic [cccl_pkg::STAMP_W-1:0]   min_stamp_r, min_stamp_nxt;
  logic [cccl_pkg::COORD_W-1:0]   min_col_r, min_col_nxt, min_row_r, min_row_nxt;
  logic [cccl_pkg::SLOT_W-1:0]    res_slot_r, res_slot_nxt;
  logic [2:0]                     res_status_r, res_status_nxt;
  logic [cccl_pkg::COORD_W-1:0]   res_ex_r, res_ex_nxt, res_ez_r, res_ez_nxt;
  logic [5:0]                     out_slot_r, out_slot_nxt;
  logic [2:0]                     out_status_r, out_status_nxt;
  logic [cccl_pkg::COORD_W-1:0]   out_ex_r, out_ex_nxt, out_ez_r, out_ez_nxt;

  logic                           ram_we;
  logic [cccl_pkg::SLOT_W-1:0]    ram_waddr, ram_raddr;
  logic [cccl_pkg::ENTRY_W-1:0]   ram_wdata, ram_rdata;
  cccl_pkg::entry_t               rd_ent;
  logic                           hit, take, last;

  cccl_ram #(
    .DEPTH (cccl_pkg::SLOTS),
    .WIDTH (cccl_pkg::ENTRY_W),
    .AW    (cccl_pkg::SLOT_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_ent   = cccl_pkg::entry_t'(ram_rdata);
  assign hit      = (rd_ent.col == cx_r) && (rd_ent.row == cz_r);
  assign take     = (idx_r == '0) || (rd_ent.stamp < min_stamp_r);
  assign last     = (cccl_pkg::CNT_W'(idx_r) + 1'b1) == used_r;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    used_nxt       = used_r;
    frame_nxt      = frame_r;
    built_nxt      = built_r;
    fbud_nxt       = fbud_r;
    out_valid_nxt  = out_valid_r;
    cx_nxt         = cx_r;
    cz_nxt         = cz_r;
    min_slot_nxt   = min_slot_r;
    min_stamp_nxt  = min_stamp_r;
    min_col_nxt    = min_col_r;
    min_row_nxt    = min_row_r;
    res_slot_nxt   = res_slot_r;
    res_status_nxt = res_status_r;
    res_ex_nxt     = res_ex_r;
    res_ez_nxt     = res_ez_r;
    out_slot_nxt   = out_slot_r;
    out_status_nxt = out_status_r;
    out_ex_nxt     = out_ex_r;
    out_ez_nxt     = out_ez_r;
    ram_we         = 1'b0;
    ram_waddr      = min_slot_r;
    ram_wdata      = {cx_r, cz_r, frame_r};
    ram_raddr      = idx_r + 1'b1;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        ram_raddr = '0;
        if (in_valid) begin
          cx_nxt     = in_cell_x;
          cz_nxt     = in_cell_z;
          res_slot_nxt = '0;
          res_ex_nxt   = '0;
          res_ez_nxt   = '0;
          if (!in_kind) begin
            frame_nxt      = frame_r + 1'b1;
            built_nxt      = '0;
            fbud_nxt       = (used_r == '0) ? cccl_pkg::BUD_W'(cccl_pkg::SLOTS)
                                            : cccl_pkg::BUD_W'(budget_r);
            res_status_nxt = cccl_pkg::ST_FRAME;
            state_nxt      = S_FIN;
          end else begin
            idx_nxt   = '0;
            state_nxt = (used_r == '0) ? S_MISS : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          ram_we         = 1'b1;
          ram_waddr      = idx_r;
          res_slot_nxt   = idx_r;
          res_status_nxt = cccl_pkg::ST_HIT;
          state_nxt      = S_FIN;
        end else begin
          if (take) begin
            min_slot_nxt  = idx_r;
            min_stamp_nxt = rd_ent.stamp;
            min_col_nxt   = rd_ent.col;
            min_row_nxt   = rd_ent.row;
          end
          idx_nxt = idx_r + 1'b1;
          if (last) begin
            state_nxt = S_MISS;
          end
        end
      end
      S_MISS: begin
        state_nxt = S_FIN;
        if (built_r >= fbud_r) begin
          res_status_nxt = cccl_pkg::ST_SKIP;
        end else begin
          ram_we    = 1'b1;
          built_nxt = built_r + 1'b1;
          if (used_r < cccl_pkg::CNT_W'(cccl_pkg::SLOTS)) begin
            ram_waddr      = cccl_pkg::SLOT_W'(used_r);
            used_nxt       = used_r + 1'b1;
            res_slot_nxt   = cccl_pkg::SLOT_W'(used_r);
            res_status_nxt = cccl_pkg::ST_BUILT;
          end else begin
            res_slot_nxt   = min_slot_r;
            res_status_nxt = cccl_pkg::ST_EVICT;
            res_ex_nxt     = min_col_r;
            res_ez_nxt     = min_row_r;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = 6'(res_slot_r);
          out_status_nxt = res_status_r;
          out_ex_nxt     = res_ex_r;
          out_ez_nxt     = res_ez_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      frame_r     <= '0;
      built_r     <= '0;
      fbud_r      <= cccl_pkg::BUD_W'(cccl_pkg::SLOTS);
      budget_r    <= cccl_pkg::CFG_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      frame_r     <= frame_nxt;
      built_r     <= built_nxt;
      fbud_r      <= fbud_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        budget_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    cx_r         <= cx_nxt;
    cz_r         <= cz_nxt;
    min_slot_r   <= min_slot_nxt;
    min_stamp_r  <= min_stamp_nxt;
    min_col_r    <= min_col_nxt;
    min_row_r    <= min_row_nxt;
    res_slot_r   <= res_slot_nxt;
    res_status_r <= res_status_nxt;
    res_ex_r     <= res_ex_nxt;
    res_ez_r     <= res_ez_nxt;
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
    out_ex_r     <= out_ex_nxt;
    out_ez_r     <= out_ez_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_slot      = out_slot_r;
  assign out_status    = out_status_r;
  assign out_evicted_x = out_ex_r;
  assign out_evicted_z = out_ez_r;

endmodule
`default_nettype wire

// ----- tb/sv/cell_chunk_cache_lru_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the cell chunk LRU cache: directed and random requests,
// predicted in place and compared against every result. Depends on cccl_pkg and the RTL.
module cell_chunk_cache_lru_test;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_CELL  = 1'b1;
  localparam int   POOL       = 96;
  localparam int   QUIET_MAX  = 4000;
  localparam int   PHASE_LEN  = 190;

  typedef struct packed {
    logic        kind;
    logic [15:0] x;
    logic [15:0] z;
  } cell_req_t;

  typedef struct packed {
    logic [5:0]  slot;
    logic [2:0]  status;
    logic [15:0] ex;
    logic [15:0] ez;
  } cache_reply_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_kind = KIND_FRAME;
  logic [15:0] in_cell_x = '0;
  logic [15:0] in_cell_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [5:0] out_slot;
  logic [2:0] out_status;
  logic [15:0] out_evicted_x;
  logic [15:0] out_evicted_z;
  logic cfg_wr_en = 1'b0;
  logic [cccl_pkg::CFG_W-1:0] cfg_wr_data = '0;

  cell_chunk_cache_lru i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_cell_x     (in_cell_x),
    .in_cell_z     (in_cell_z),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_slot      (out_slot),
    .out_status    (out_status),
    .out_evicted_x (out_evicted_x),
    .out_evicted_z (out_evicted_z),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // cache image kept by the testbench
  logic [15:0] tag_x [cccl_pkg::SLOTS];
  logic [15:0] tag_z [cccl_pkg::SLOTS];
  logic [31:0] stamp [cccl_pkg::SLOTS];
  int          fill_count = 0;
  logic [31:0] frame_ctr = '0;
  int          built_cnt = 0;
  int          frame_limit = cccl_pkg::SLOTS;
  logic [6:0]  budget_reg = 7'd1;

  cell_req_t    req_q[$];
  cache_reply_t replies_due[$];
  int n_in_sent = 0;
  int n_in_taken = 0;
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int errors = 0;
  int quiet = 0;

  logic [15:0] pool_x [POOL];
  logic [15:0] pool_z [POOL];

  task automatic lookup_cell(input logic kind, input logic [15:0] cx, input logic [15:0] cz);
    cache_reply_t r;
    int victim;
    bit found;
    r = '0;
    found = 1'b0;
    if (kind == KIND_FRAME) begin
      frame_ctr   = frame_ctr + 32'd1;
      built_cnt   = 0;
      frame_limit = (fill_count == 0) ? cccl_pkg::SLOTS : int'(budget_reg);
      r.status    = cccl_pkg::ST_FRAME;
    end else begin
      for (int i = 0; i < fill_count && !found; i++) begin
        if (tag_x[i] == cx && tag_z[i] == cz) begin
          stamp[i] = frame_ctr;
          r.slot   = 6'(i);
          r.status = cccl_pkg::ST_HIT;
          found    = 1'b1;
        end
      end
      if (!found) begin
        if (built_cnt >= frame_limit) begin
          r.status = cccl_pkg::ST_SKIP;
        end else begin
          if (fill_count < cccl_pkg::SLOTS) begin
            victim     = fill_count;
            fill_count = fill_count + 1;
            r.status   = cccl_pkg::ST_BUILT;
          end else begin
            victim = 0;
            for (int i = 1; i < cccl_pkg::SLOTS; i++) begin
              if (stamp[i] < stamp[victim]) victim = i;
            end
            r.ex     = tag_x[victim];
            r.ez     = tag_z[victim];
            r.status = cccl_pkg::ST_EVICT;
          end
          tag_x[victim] = cx;
          tag_z[victim] = cz;
          stamp[victim] = frame_ctr;
          built_cnt     = built_cnt + 1;
          r.slot        = 6'(victim);
        end
      end
    end
    replies_due.push_back(r);
  endtask

  // driver
  always @(negedge clk) begin : drv
    cell_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || n_in_sent == n_in_taken) begin
      if (req_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
        nxt = req_q.pop_front();
        in_kind   <= nxt.kind;
        in_cell_x <= nxt.x;
        in_cell_z <= nxt.z;
        in_valid  <= 1'b1;
        n_in_sent <= n_in_sent + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
  end

  // monitor: results checked before the new request is predicted
  always @(posedge clk) begin : mon
    cache_reply_t due;
    bit got_in;
    bit got_out;
    if (rst_n) begin
      got_in  = in_valid && !in_stall;
      got_out = out_valid && !out_stall;
      if (got_out) begin
        if (replies_due.size() == 0) begin
          errors++;
          $error("result with no request outstanding: slot %0d status %0d",
                 out_slot, out_status);
        end else begin
          due = replies_due.pop_front();
          if (out_slot !== due.slot) begin
            errors++;
            $error("slot: expected %0d, got %0d", due.slot, out_slot);
          end
          if (out_status !== due.status) begin
            errors++;
            $error("status: expected %0d, got %0d", due.status, out_status);
          end
          if (out_evicted_x !== due.ex) begin
            errors++;
            $error("evicted_x: expected %h, got %h", due.ex, out_evicted_x);
          end
          if (out_evicted_z !== due.ez) begin
            errors++;
            $error("evicted_z: expected %h, got %h", due.ez, out_evicted_z);
          end
        end
      end
      if (got_in) begin
        lookup_cell(in_kind, in_cell_x, in_cell_z);
        n_in_taken <= n_in_taken + 1;
      end
      if (got_in || got_out) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (quiet >= QUIET_MAX) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic queue_item(input logic kind, input logic [15:0] x, input logic [15:0] z);
    cell_req_t r;
    r.kind = kind;
    r.x    = x;
    r.z    = z;
    req_q.push_back(r);
  endtask

  task automatic drain;
    while (req_q.size() != 0 || n_in_sent != n_in_taken || replies_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_budget(input logic [6:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    budget_reg  = v;
  endtask

  function automatic logic [15:0] corner(input int k);
    case (k)
      0:       corner = 16'h8000;
      1:       corner = 16'h7FFF;
      2:       corner = 16'hFFFF;
      default: corner = 16'h0000;
    endcase
  endfunction

  // mostly requests from a drifting working set, some frame starts, fresh cells and corners
  function automatic cell_req_t next_random_item(input int n);
    cell_req_t r;
    int roll;
    int idx;
    roll   = $urandom_range(0, 99);
    r.kind = KIND_CELL;
    r.x    = 16'($urandom);
    r.z    = 16'($urandom);
    if (roll < 9) begin
      r.kind = KIND_FRAME;
    end else if (roll < 15) begin
    end else if (roll < 18) begin
      r.x = corner($urandom_range(0, 3));
      r.z = corner($urandom_range(0, 3));
    end else begin
      idx = (n / 8 + $urandom_range(0, 79)) % POOL;
      r.x = pool_x[idx];
      r.z = pool_z[idx];
    end
    return r;
  endfunction

  initial begin : stim
    logic [6:0] budgets [10];
    int n;
    n = 0;
    budgets = '{7'd64, 7'd1, 7'd127, 7'd2, 7'd0, 7'd5, 7'd64, 7'd1,
                7'($urandom_range(1, 64)), 7'd33};
    for (int i = 0; i < POOL; i++) begin
      pool_x[i] = 16'($urandom);
      pool_z[i] = 16'($urandom);
      if (i > 0 && $urandom_range(0, 3) == 0) pool_x[i] = pool_x[i-1];
      else if (i > 0 && $urandom_range(0, 2) == 0) pool_z[i] = pool_z[i-1];
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    snd_idle_pct  = 25;
    rcv_stall_pct = 59;

    // zero budget; requests before any frame start still build (frame zero)
    set_budget(7'd0);
    queue_item(KIND_CELL, 16'h8000, 16'h7FFF);
    queue_item(KIND_CELL, 16'h7FFF, 16'h8000);
    queue_item(KIND_CELL, 16'h0000, 16'h0000);
    queue_item(KIND_CELL, 16'hFFFF, 16'hFFFF);
    queue_item(KIND_CELL, 16'h0000, 16'h0000);
    queue_item(KIND_CELL, 16'h8000, 16'h7FFF);
    queue_item(KIND_CELL, 16'h0000, 16'hFFFF);
    queue_item(KIND_CELL, 16'hFFFF, 16'h0000);
    queue_item(KIND_FRAME, 16'hFFFF, 16'hFFFF);
    queue_item(KIND_CELL, 16'h1234, 16'h5678);
    queue_item(KIND_CELL, 16'h7FFF, 16'h8000);
    queue_item(KIND_FRAME, 16'h0000, 16'h0000);
    drain();

    set_budget(7'd1);
    queue_item(KIND_FRAME, 16'h8000, 16'h7FFF);
    queue_item(KIND_CELL, 16'hAAAA, 16'h5555);
    queue_item(KIND_CELL, 16'h5555, 16'hAAAA);
    queue_item(KIND_CELL, 16'hAAAA, 16'h5555);
    queue_item(KIND_FRAME, 16'h0000, 16'h0000);
    queue_item(KIND_CELL, 16'h5555, 16'hAAAA);
    queue_item(KIND_CELL, 16'h7FFF, 16'h7FFF);
    drain();

    for (int p = 0; p < 10; p++) begin
      if (p < 4) begin
        snd_idle_pct  = 25;
        rcv_stall_pct = 59;
      end else if (p < 7) begin
        snd_idle_pct  = 59;
        rcv_stall_pct = 25;
      end else begin
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
      end
      set_budget(budgets[p]);
      for (int k = 0; k < PHASE_LEN; k++) begin
        req_q.push_back(next_random_item(n));
        n++;
      end
      drain();
    end

    repeat (80) @(posedge clk);
    if (errors == 0 && replies_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/cccl_pkg.sv
rtl/cccl_ram.sv
rtl/cell_chunk_cache_lru.sv
tb/sv/cell_chunk_cache_lru_test.sv
